// ===== rtl/assert_macros.svh =====
// Assertion shorthands: clocked on clk, disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/qea_pkg.sv =====
package qea_pkg;

    localparam int COUNT_BITS_DEFAULT = 32;
    localparam int POS_BITS           = 32;
    localparam int ACCEL_BITS         = 16;
    localparam int TIME_BITS          = 10;
    localparam int ACCUM_BITS         = 11;
    localparam int STEP_BITS          = 2;
    localparam int CFG_INDEX_BITS     = 2;

    localparam logic [TIME_BITS-1:0] DECAY_PERIOD_RESET = TIME_BITS'(10);

    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEBOUNCE_MS     = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DECAY_PERIOD_MS = CFG_INDEX_BITS'(1);

    typedef struct packed {
        logic [TIME_BITS-1:0] debounce_ms;
        logic [TIME_BITS-1:0] decay_period_ms;
    } qea_cfg_t;

    typedef struct packed {
        logic [ACCEL_BITS-1:0] accel;
        logic [TIME_BITS-1:0]  debounce_left;
        logic [ACCUM_BITS-1:0] decay_accum;
        logic                  last_a;
        logic                  last_b;
    } qea_state_t;

    typedef struct packed {
        logic signed [POS_BITS-1:0] position;
        logic [ACCEL_BITS-1:0]      acceleration;
        logic [STEP_BITS-1:0]       step_events;
    } qea_result_t;

endpackage

// ===== rtl/qea_step.sv =====
module qea_step
    import qea_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  qea_cfg_t               cfg,
    input  qea_state_t             cur,
    input  logic [COUNT_BITS-1:0]  count_cur,
    input  logic                   action,
    input  logic [TIME_BITS-1:0]   elapsed_ms,
    input  logic                   pin_a,
    input  logic                   pin_b,
    output qea_state_t             nxt,
    output logic [COUNT_BITS-1:0]  count_nxt,
    output logic [STEP_BITS-1:0]   steps
);

    logic                  tick;
    logic [ACCUM_BITS:0]   accum_sum;
    logic [ACCUM_BITS-1:0] accum_wrap;
    logic                  decay_hit;
    logic [ACCEL_BITS-1:0] accel_dec;
    logic [TIME_BITS-1:0]  deb_dec;
    logic                  open;
    logic                  a_chg;
    logic                  b_chg;
    logic                  a_step;
    logic                  b_step;
    logic [1:0]            inc;
    logic [ACCEL_BITS:0]   accel_sum;
    logic signed [2:0]     da;
    logic signed [2:0]     db;
    logic signed [2:0]     delta;

    assign tick       = !action && (elapsed_ms != '0);
    assign accum_sum  = {1'b0, cur.decay_accum} + {{(ACCUM_BITS-TIME_BITS+1){1'b0}}, elapsed_ms};
    assign accum_wrap = accum_sum[ACCUM_BITS-1:0];
    assign decay_hit  = accum_wrap >= {{(ACCUM_BITS-TIME_BITS){1'b0}}, cfg.decay_period_ms};
    assign accel_dec  = (decay_hit && (cur.accel != '0)) ? cur.accel - 1'b1 : cur.accel;
    assign deb_dec    = (cur.debounce_left > elapsed_ms) ? cur.debounce_left - elapsed_ms
                                                         : '0;
    assign open       = tick && (deb_dec == '0);
    assign a_chg      = open && (pin_a != cur.last_a);
    assign b_chg      = open && (pin_b != cur.last_b);
    assign a_step     = a_chg && !pin_a;
    assign b_step     = b_chg && !pin_b;
    assign inc        = {1'b0, a_step} + {1'b0, b_chg};
    assign accel_sum  = {1'b0, accel_dec} + {{(ACCEL_BITS-1){1'b0}}, inc};

    assign da    = a_step ? (pin_b  ? 3'sd1 : -3'sd1) : 3'sd0;
    assign db    = b_step ? (!pin_a ? 3'sd1 : -3'sd1) : 3'sd0;
    assign delta = da + db;

    always_comb
    begin
        nxt       = cur;
        count_nxt = count_cur;
        steps     = '0;
        if (action)
        begin
            nxt.accel         = '0;
            nxt.debounce_left = '0;
            nxt.last_a        = pin_a;
            nxt.last_b        = pin_b;
        end
        else if (tick)
        begin
            nxt.decay_accum   = decay_hit ? '0 : accum_wrap;
            nxt.accel         = accel_sum[ACCEL_BITS] ? '1 : accel_sum[ACCEL_BITS-1:0];
            nxt.debounce_left = (a_chg || b_chg) ? cfg.debounce_ms : deb_dec;
            nxt.last_a        = a_chg ? pin_a : cur.last_a;
            nxt.last_b        = b_chg ? pin_b : cur.last_b;
            count_nxt         = count_cur + {{(COUNT_BITS-3){delta[2]}}, delta};
            steps             = {1'b0, a_step} + {1'b0, b_step};
        end
    end

endmodule

// ===== rtl/quadrature_encoder_with_acceleration_core.sv =====
// Quadrature encoder decoder with acceleration level.
// Results go to the output word register, or the skid word on a stall.
// Throughput: one word per cycle while in_ready; a single registered state pass.
// A two-entry output stage keeps input flowing while one result waits.
// Reset (rst_n, async, active low): count, acceleration, timers cleared,
// last pins high, debounce 0 and decay period 10; no clearing pass.
module quadrature_encoder_with_acceleration_core
    import qea_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [TIME_BITS-1:0]       cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       action,
    input  logic [TIME_BITS-1:0]       elapsed_ms,
    input  logic                       pin_a,
    input  logic                       pin_b,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [POS_BITS-1:0] position,
    output logic [ACCEL_BITS-1:0]      acceleration,
    output logic [STEP_BITS-1:0]       step_events
);

    qea_cfg_t              cfg_reg;
    qea_state_t            state_reg;
    qea_state_t            state_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [STEP_BITS-1:0]  steps;
    logic [POS_BITS-1:0]   pos_ext;
    qea_result_t           result;
    qea_result_t           out_word_reg;
    qea_result_t           skid_word_reg;
    logic                  out_valid_reg;
    logic                  skid_valid_reg;
    logic                  accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = !skid_valid_reg;
    assign accept    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms     <= '0;
            cfg_reg.decay_period_ms <= DECAY_PERIOD_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE_MS:     cfg_reg.debounce_ms     <= cfg_data;
                CFG_DECAY_PERIOD_MS: cfg_reg.decay_period_ms <= cfg_data;
                default:             ;
            endcase
        end
    end

    qea_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_qea_step (
        .cfg        (cfg_reg),
        .cur        (state_reg),
        .count_cur  (count_reg),
        .action     (action),
        .elapsed_ms (elapsed_ms),
        .pin_a      (pin_a),
        .pin_b      (pin_b),
        .nxt        (state_next),
        .count_nxt  (count_next),
        .steps      (steps)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.accel         <= '0;
            state_reg.debounce_left <= '0;
            state_reg.decay_accum   <= '0;
            state_reg.last_a        <= 1'b1;
            state_reg.last_b        <= 1'b1;
            count_reg               <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    generate
        if (COUNT_BITS >= POS_BITS)
        begin : g_pos_trunc
            assign pos_ext = count_next[POS_BITS-1:0];
        end
        else
        begin : g_pos_sext
            assign pos_ext = {{(POS_BITS-COUNT_BITS){count_next[COUNT_BITS-1]}}, count_next};
        end
    endgenerate

    assign result.position     = $signed(pos_ext);
    assign result.acceleration = state_next.accel;
    assign result.step_events  = steps;

    // output word plus skid word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            out_word_reg <= skid_valid_reg ? skid_word_reg : result;
        end
        else if (accept)
        begin
            skid_word_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign position     = out_word_reg.position;
    assign acceleration = out_word_reg.acceleration;
    assign step_events  = out_word_reg.step_events;

endmodule

// ===== rtl/qea_checker.sv =====
`include "assert_macros.svh"

module qea_checker
    import qea_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       action,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic signed [POS_BITS-1:0] position,
    input logic [ACCEL_BITS-1:0]      acceleration,
    input logic [STEP_BITS-1:0]       step_events
);

    // a stalled result word holds
    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(position) && $stable(acceleration) && $stable(step_events))
    // input only stalls when a result word is waiting
    `ASSERT_IMP(a_stall_cause, !in_ready, out_valid)
    // an accepted word into an empty output appears next cycle
    `ASSERT_NEXT(a_latency, in_valid && in_ready && !out_valid, out_valid)
    // init clears acceleration and reports no steps
    `ASSERT_NEXT(a_init, in_valid && in_ready && !out_valid && action, acceleration == '0 && step_events == '0)
    // at most two count changes per word
    `ASSERT_IMP(a_steps_range, out_valid, step_events != 2'd3)

endmodule

bind quadrature_encoder_with_acceleration_core qea_checker u_qea_checker (.*);
